/* rtl/core/slla_pkg.sv */
// shared constants, word types and memory port structs for the pool assigner
`default_nettype none
package slla_pkg;

  // table and pool sizing
  localparam int MAX_ENTRIES = 64;
  localparam int MAX_POOLS   = 8;

  localparam int ENT_IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int ENT_CW  = $clog2(MAX_ENTRIES + 1);
  localparam int SLOT_W  = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int POOL_CW = $clog2(MAX_POOLS + 1);
  localparam int LOAD_W  = $clog2(MAX_ENTRIES + 1);

  // fixed field widths
  localparam int CMD_W      = 2;
  localparam int DISK_W     = 32;
  localparam int CFG_W      = 4;
  localparam int OUT_SLOT_W = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ACQUIRE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [DISK_W-1:0] disk_id;
  } in_word_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] pool_slot;
    logic                  found;
    logic                  table_full;
  } out_word_t;

  // entry store port
  typedef struct packed {
    logic              rd_en;
    logic [ENT_IW-1:0] rd_idx;
    logic              we;
    logic [ENT_IW-1:0] wr_idx;
    logic [DISK_W-1:0] wr_disk;
    logic [SLOT_W-1:0] wr_slot;
    logic              clr;
    logic [ENT_IW-1:0] clr_idx;
  } ent_req_t;

  typedef struct packed {
    logic              vld;
    logic [DISK_W-1:0] disk;
    logic [SLOT_W-1:0] slot;
  } ent_rsp_t;

  // pool load store port
  typedef struct packed {
    logic [SLOT_W-1:0] rd_addr;
    logic              we;
    logic [SLOT_W-1:0] wr_addr;
    logic [LOAD_W-1:0] wr_load;
  } pool_req_t;

  typedef struct packed {
    logic [LOAD_W-1:0] load;
  } pool_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/slla_entry_store.sv */
// entry memory (disk id and slot) with per-entry valid flops
`default_nettype none
module slla_entry_store (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire slla_pkg::ent_req_t req,
  output slla_pkg::ent_rsp_t     rsp
);

  localparam int DW = slla_pkg::DISK_W + slla_pkg::SLOT_W;

  logic [DW-1:0]                    ent_mem [slla_pkg::MAX_ENTRIES];
  logic [slla_pkg::MAX_ENTRIES-1:0] vld_r;
  logic [DW-1:0]                    rd_data_r;
  logic                             rd_vld_r;

  // payload memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      ent_mem[req.wr_idx] <= {req.wr_disk, req.wr_slot};
    end
    if (req.rd_en) begin
      rd_data_r <= ent_mem[req.rd_idx];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.wr_idx] <= 1'b1;
      end
      if (req.clr) begin
        vld_r[req.clr_idx] <= 1'b0;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_idx];
      end
    end
  end

  assign rsp.vld  = rd_vld_r;
  assign rsp.disk = rd_data_r[DW-1:slla_pkg::SLOT_W];
  assign rsp.slot = rd_data_r[slla_pkg::SLOT_W-1:0];

endmodule
`default_nettype wire

/* rtl/core/slla_pool_store.sv */
// per-pool load memory; an entry never written since reset reads as zero
`default_nettype none
module slla_pool_store (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire slla_pkg::pool_req_t req,
  output slla_pkg::pool_rsp_t     rsp
);

  logic [slla_pkg::LOAD_W-1:0]    load_mem [slla_pkg::MAX_POOLS];
  logic [slla_pkg::MAX_POOLS-1:0] vld_r;
  logic [slla_pkg::LOAD_W-1:0]    rd_data_r;
  logic                           rd_vld_r;

  // load memory, registered read every cycle
  always_ff @(posedge clk) begin
    if (req.we) begin
      load_mem[req.wr_addr] <= req.wr_load;
    end
    rd_data_r <= load_mem[req.rd_addr];
  end

  // written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      rd_vld_r <= vld_r[req.rd_addr];
    end
  end

  assign rsp.load = rd_vld_r ? rd_data_r : '0;

endmodule
`default_nettype wire

/* rtl/core/sticky_least_loaded_pool_assigner.sv */
// Sticky least-loaded pool assigner: sequencer over entry and pool load memories.
// One word at a time; the entry memory is scanned one entry per cycle.
// Find, a kept assignment and a full table go from the scan to the result; release also
// lowers the pool's load on a hit, and a new assignment first walks the active pools.
// Reset: synchronous, active low; clears all entries and pool loads at once and sets
// pools_r to 1.
`default_nettype none
module sticky_least_loaded_pool_assigner (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire slla_pkg::in_word_t           in_word,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output slla_pkg::out_word_t               out_word,
  input  wire logic                         cfg_wr_en,
  input  wire logic [slla_pkg::CFG_W-1:0]   cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PSCAN,
    ST_COMMIT,
    ST_PREL,
    ST_OUT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [slla_pkg::CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [slla_pkg::DISK_W-1:0]     disk_r, disk_nxt;
  logic [slla_pkg::ENT_CW-1:0]     cnt_r, cnt_nxt;
  logic                            tag_vld_r, tag_vld_nxt;
  logic [slla_pkg::ENT_IW-1:0]     tag_idx_r, tag_idx_nxt;
  logic                            hit_r, hit_nxt;
  logic [slla_pkg::ENT_IW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [slla_pkg::SLOT_W-1:0]     hit_slot_r, hit_slot_nxt;
  logic                            free_r, free_nxt;
  logic [slla_pkg::ENT_IW-1:0]     free_idx_r, free_idx_nxt;
  logic [slla_pkg::POOL_CW-1:0]    pcnt_r, pcnt_nxt;
  logic                            ptag_vld_r, ptag_vld_nxt;
  logic [slla_pkg::SLOT_W-1:0]     ptag_idx_r, ptag_idx_nxt;
  logic [slla_pkg::SLOT_W-1:0]     best_r, best_nxt;
  logic [slla_pkg::LOAD_W-1:0]     best_load_r, best_load_nxt;
  slla_pkg::out_word_t             res_r, res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  slla_pkg::out_word_t             out_word_r, out_word_nxt;
  logic [slla_pkg::CFG_W-1:0]      pools_r, pools_nxt;

  logic [slla_pkg::POOL_CW-1:0]    active_n;
  slla_pkg::ent_req_t              ent_req;
  slla_pkg::ent_rsp_t              ent_rsp;
  slla_pkg::pool_req_t             pool_req;
  slla_pkg::pool_rsp_t             pool_rsp;

  slla_entry_store u_entry_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ent_req),
    .rsp   (ent_rsp)
  );

  slla_pool_store u_pool_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pool_req),
    .rsp   (pool_rsp)
  );

  // number of pools taking part in the least-loaded pick
  always_comb begin
    if (pools_r == '0) begin
      active_n = slla_pkg::POOL_CW'(1);
    end else if (32'(pools_r) > 32'(slla_pkg::MAX_POOLS)) begin
      active_n = slla_pkg::POOL_CW'(slla_pkg::MAX_POOLS);
    end else begin
      active_n = slla_pkg::POOL_CW'(pools_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    disk_nxt      = disk_r;
    cnt_nxt       = cnt_r;
    tag_vld_nxt   = 1'b0;
    tag_idx_nxt   = tag_idx_r;
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_slot_nxt  = hit_slot_r;
    free_nxt      = free_r;
    free_idx_nxt  = free_idx_r;
    pcnt_nxt      = pcnt_r;
    ptag_vld_nxt  = 1'b0;
    ptag_idx_nxt  = ptag_idx_r;
    best_nxt      = best_r;
    best_load_nxt = best_load_r;
    res_nxt       = res_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    pools_nxt     = cfg_wr_en ? cfg_wr_data : pools_r;
    ent_req       = '0;
    pool_req      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_word.command;
          disk_nxt  = in_word.disk_id;
          cnt_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue the next entry read
        if (cnt_r < slla_pkg::ENT_CW'(slla_pkg::MAX_ENTRIES)) begin
          ent_req.rd_en = 1'b1;
          ent_req.rd_idx = cnt_r[slla_pkg::ENT_IW-1:0];
          cnt_nxt       = cnt_r + 1'b1;
          tag_vld_nxt   = 1'b1;
          tag_idx_nxt   = cnt_r[slla_pkg::ENT_IW-1:0];
        end
        // check the entry read last cycle: first match and first free position
        if (tag_vld_r) begin
          if (ent_rsp.vld && (ent_rsp.disk == disk_r) && !hit_r) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = tag_idx_r;
            hit_slot_nxt = ent_rsp.slot;
          end
          if (!ent_rsp.vld && !free_r) begin
            free_nxt     = 1'b1;
            free_idx_nxt = tag_idx_r;
          end
          if (tag_idx_r == slla_pkg::ENT_IW'(slla_pkg::MAX_ENTRIES - 1)) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        res_nxt   = '0;
        state_nxt = ST_OUT;
        unique case (cmd_r)
          slla_pkg::CMD_ACQUIRE: begin
            if (hit_r) begin
              res_nxt.pool_slot = slla_pkg::OUT_SLOT_W'(hit_slot_r);
              res_nxt.found     = 1'b1;
            end else if (!free_r) begin
              res_nxt.table_full = 1'b1;
            end else begin
              pcnt_nxt  = '0;
              state_nxt = ST_PSCAN;
            end
          end
          slla_pkg::CMD_RELEASE: begin
            if (hit_r) begin
              ent_req.clr      = 1'b1;
              ent_req.clr_idx  = hit_idx_r;
              pool_req.rd_addr = hit_slot_r;
              res_nxt.pool_slot = slla_pkg::OUT_SLOT_W'(hit_slot_r);
              res_nxt.found     = 1'b1;
              state_nxt         = ST_PREL;
            end
          end
          slla_pkg::CMD_FIND: begin
            if (hit_r) begin
              res_nxt.pool_slot = slla_pkg::OUT_SLOT_W'(hit_slot_r);
              res_nxt.found     = 1'b1;
            end
          end
          default: begin
            res_nxt = '0;
          end
        endcase
      end

      ST_PSCAN: begin
        // walk the active pools, keeping the first lowest load
        if (pcnt_r < active_n) begin
          pool_req.rd_addr = pcnt_r[slla_pkg::SLOT_W-1:0];
          pcnt_nxt         = pcnt_r + 1'b1;
          ptag_vld_nxt     = 1'b1;
          ptag_idx_nxt     = pcnt_r[slla_pkg::SLOT_W-1:0];
        end
        if (ptag_vld_r) begin
          if ((ptag_idx_r == '0) || (pool_rsp.load < best_load_r)) begin
            best_nxt      = ptag_idx_r;
            best_load_nxt = pool_rsp.load;
          end
          if ((slla_pkg::POOL_CW'(ptag_idx_r) + slla_pkg::POOL_CW'(1)) == active_n) begin
            state_nxt = ST_COMMIT;
          end
        end
      end

      ST_COMMIT: begin
        // record the new entry and count it
        ent_req.we       = 1'b1;
        ent_req.wr_idx   = free_idx_r;
        ent_req.wr_disk  = disk_r;
        ent_req.wr_slot  = best_r;
        pool_req.we      = 1'b1;
        pool_req.wr_addr = best_r;
        pool_req.wr_load = best_load_r + 1'b1;
        res_nxt          = '0;
        res_nxt.pool_slot = slla_pkg::OUT_SLOT_W'(best_r);
        state_nxt        = ST_OUT;
      end

      ST_PREL: begin
        // lower the released pool's load, never below zero
        if (pool_rsp.load != '0) begin
          pool_req.we      = 1'b1;
          pool_req.wr_addr = hit_slot_r;
          pool_req.wr_load = pool_rsp.load - 1'b1;
        end
        state_nxt = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tag_vld_r   <= 1'b0;
      ptag_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pools_r     <= slla_pkg::CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      tag_vld_r   <= tag_vld_nxt;
      ptag_vld_r  <= ptag_vld_nxt;
      out_valid_r <= out_valid_nxt;
      pools_r     <= pools_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    disk_r      <= disk_nxt;
    cnt_r       <= cnt_nxt;
    tag_idx_r   <= tag_idx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_slot_r  <= hit_slot_nxt;
    free_r      <= free_nxt;
    free_idx_r  <= free_idx_nxt;
    pcnt_r      <= pcnt_nxt;
    ptag_idx_r  <= ptag_idx_nxt;
    best_r      <= best_nxt;
    best_load_r <= best_load_nxt;
    res_r       <= res_nxt;
    out_word_r  <= out_word_nxt;
  end

`ifndef SYNTHESIS
  // a new entry is only written for an acquire that missed and found room
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |-> (free_r && !hit_r && (cmd_r == slla_pkg::CMD_ACQUIRE)))
    else $error("entry written without a free position");

  // a pool load is lowered only for a release that hit
  a_release_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREL) |-> (hit_r && (cmd_r == slla_pkg::CMD_RELEASE)))
    else $error("pool load lowered without a matching entry");

  // a result word appears only out of the output state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result word raised outside the output state");

  // an accepted word always starts a table scan
  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");
`endif

endmodule
`default_nettype wire
